// ===== src/priority_thread_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// priority thread scheduler assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef PRIORITY_THREAD_SCHEDULER_DEFINES_SVH
`define PRIORITY_THREAD_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on clk_i, off while rst_ni is low
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// property checked on clk_i at every edge, reset included
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PTS_ASSERT(lbl, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// shared constants, codes and types of the priority thread scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MaxThreads = 16;
  localparam int TidW       = $clog2(MaxThreads);
  localparam int PrioLevels = 4;
  localparam int LvW        = $clog2(PrioLevels);
  localparam int SemSlots   = 8;
  localparam int SidW       = $clog2(SemSlots);
  localparam int QCntW      = $clog2(MaxThreads + 1);
  localparam int RdyAw      = LvW + TidW;
  localparam int SemAw      = SidW + TidW;
  localparam int SemCntW    = 9;
  localparam int InitW      = 8;
  localparam int OpW        = 3;
  localparam int PrioInW    = 3;
  localparam int ResW       = 2;

  localparam logic signed [SemCntW-1:0] SemHigh = 9'sh0ff;
  localparam logic signed [SemCntW-1:0] SemLow  = 9'sh100;

  typedef enum logic [OpW-1:0] {
    OP_CREATE   = 3'd0,
    OP_YIELD    = 3'd1,
    OP_JOIN     = 3'd2,
    OP_EXIT     = 3'd3,
    OP_SEM_INIT = 3'd4,
    OP_SEM_WAIT = 3'd5,
    OP_SEM_SIG  = 3'd6,
    OP_SET_PRIO = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    TS_FREE    = 3'd0,
    TS_READY   = 3'd1,
    TS_RUNNING = 3'd2,
    TS_BJOIN   = 3'd3,
    TS_BSEM    = 3'd4
  } thr_stat_e;

  typedef enum logic [ResW-1:0] {
    RES_OK    = 2'd0,
    RES_ERR   = 2'd1,
    RES_NORUN = 2'd2
  } res_stat_e;

  typedef struct packed {
    logic [LvW-1:0]  prio;
    thr_stat_e       stat;
    logic            join_v;
    logic [TidW-1:0] join_tid;
  } tt_entry_t;

  typedef struct packed {
    logic            en;
    logic [TidW-1:0] addr;
    logic            prio_we;
    logic            stat_we;
    logic            join_we;
    tt_entry_t       data;
  } tt_wr_t;

  typedef struct packed {
    logic [TidW-1:0]  head;
    logic [TidW-1:0]  tail;
    logic [QCntW-1:0] cnt;
  } qctl_t;

endpackage

// ===== src/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_if
// valid/ready channels for scheduler operations and results
// ----------------------------------------------------------------------------
interface pts_op_if;
  logic                         valid;
  logic                         ready;
  logic [pts_pkg::OpW-1:0]      opcode;
  logic [pts_pkg::PrioInW-1:0]  prio;
  logic [pts_pkg::TidW-1:0]     target_tid;
  logic [pts_pkg::SidW-1:0]     sem_id;
  logic [pts_pkg::InitW-1:0]    init_count;

  modport source (output valid, opcode, prio, target_tid, sem_id, init_count, input ready);
  modport sink   (input valid, opcode, prio, target_tid, sem_id, init_count, output ready);
endinterface

interface pts_res_if;
  logic                      valid;
  logic                      ready;
  logic [pts_pkg::ResW-1:0]  status;
  logic [pts_pkg::TidW-1:0]  new_tid;
  logic [pts_pkg::TidW-1:0]  running_tid;
  logic                      running_valid;

  modport source (output valid, status, new_tid, running_tid, running_valid, input ready);
  modport sink   (input valid, status, new_tid, running_tid, running_valid, output ready);
endinterface

// ===== src/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int Depth = 64,
  parameter int Width = 4,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/pts_thread_tbl.sv =====
// ----------------------------------------------------------------------------
// pts_thread_tbl
// per-thread priority, status and join wait, one read and one write a cycle
// ----------------------------------------------------------------------------
module pts_thread_tbl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pts_pkg::TidW-1:0] rd_addr_i,
  output pts_pkg::tt_entry_t       rd_data_o,
  input  pts_pkg::tt_wr_t          wr_i
);

  pts_pkg::tt_entry_t tbl_q [pts_pkg::MaxThreads];

  // read at the one address the sequencer selects
  assign rd_data_o = tbl_q[rd_addr_i];

  // field-masked write, thread 0 comes out of reset running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pts_pkg::MaxThreads; i++) begin
        tbl_q[i].prio     <= '0;
        tbl_q[i].stat     <= (i == 0) ? pts_pkg::TS_RUNNING : pts_pkg::TS_FREE;
        tbl_q[i].join_v   <= 1'b0;
        tbl_q[i].join_tid <= '0;
      end
    end else if (wr_i.en) begin
      if (wr_i.prio_we) begin
        tbl_q[wr_i.addr].prio <= wr_i.data.prio;
      end
      if (wr_i.stat_we) begin
        tbl_q[wr_i.addr].stat <= wr_i.data.stat;
      end
      if (wr_i.join_we) begin
        tbl_q[wr_i.addr].join_v   <= wr_i.data.join_v;
        tbl_q[wr_i.addr].join_tid <= wr_i.data.join_tid;
      end
    end
  end

endmodule

// ===== src/priority_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_thread_scheduler
// strict-priority scheduler: ready and semaphore queues live in rams,
// a sequencer reads, modifies and writes back one access at a time
// ----------------------------------------------------------------------------
//  port    dir   items carried
//  in_i    sink  one scheduler operation per item
//  out_o   src   status, new thread id and running thread, one per operation
//
//  one operation at a time; join and exit scan up to 16 join-wait entries,
//  and set_prio of a ready thread walks the level's ready-queue ram entry
//  by entry through its single read port.
//  reset is immediate, the queue rams need no clearing pass.
//  a new item is taken while the last result still waits at the output.
// ----------------------------------------------------------------------------
`include "priority_thread_scheduler_defines.svh"

module priority_thread_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_op_if.sink    in_i,
  pts_res_if.source out_o
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DECODE  = 15'b000000000000010,
    S_JSCAN   = 15'b000000000000100,
    S_CHK     = 15'b000000000001000,
    S_MKRDY   = 15'b000000000010000,
    S_DISP    = 15'b000000000100000,
    S_DISPWB  = 15'b000000001000000,
    S_SIGWB   = 15'b000000010000000,
    S_RMRD    = 15'b000000100000000,
    S_RMCMP   = 15'b000001000000000,
    S_SHRD    = 15'b000010000000000,
    S_SHWR    = 15'b000100000000000,
    S_RMEND   = 15'b001000000000000,
    S_SETPFIN = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_e;

  state_e                              state_q, state_d;
  pts_pkg::opcode_e                    op_q, op_d;
  logic [pts_pkg::PrioInW-1:0]         prio_q, prio_d;
  logic [pts_pkg::TidW-1:0]            tid_q, tid_d;
  logic [pts_pkg::SidW-1:0]            sid_q, sid_d;
  logic [pts_pkg::InitW-1:0]           initc_q, initc_d;
  pts_pkg::res_stat_e                  res_q, res_d;
  logic [pts_pkg::TidW-1:0]            newtid_q, newtid_d;
  logic                                run_q, run_d;
  logic [pts_pkg::TidW-1:0]            cur_q, cur_d;
  logic [pts_pkg::TidW-1:0]            next_tid_q, next_tid_d;
  logic [pts_pkg::TidW-1:0]            mr_tid_q, mr_tid_d;
  logic                                disp_after_q, disp_after_d;
  logic [pts_pkg::TidW-1:0]            scan_q, scan_d;
  logic [pts_pkg::TidW-1:0]            k_q, k_d;
  logic [pts_pkg::LvW-1:0]             lv_q, lv_d;
  pts_pkg::qctl_t                      rq_q [pts_pkg::PrioLevels];
  pts_pkg::qctl_t                      rq_d [pts_pkg::PrioLevels];
  pts_pkg::qctl_t                      sq_q [pts_pkg::SemSlots];
  pts_pkg::qctl_t                      sq_d [pts_pkg::SemSlots];
  logic signed [pts_pkg::SemCntW-1:0]  scnt_q [pts_pkg::SemSlots];
  logic signed [pts_pkg::SemCntW-1:0]  scnt_d [pts_pkg::SemSlots];
  logic [pts_pkg::SemSlots-1:0]        sinit_q, sinit_d;
  logic                                ov_q, ov_d;
  pts_pkg::res_stat_e                  ostat_q, ostat_d;
  logic [pts_pkg::TidW-1:0]            onew_q, onew_d;
  logic [pts_pkg::TidW-1:0]            orun_tid_q, orun_tid_d;
  logic                                orun_v_q, orun_v_d;

  logic [pts_pkg::TidW-1:0]            tt_raddr;
  pts_pkg::tt_entry_t                  tt_rd;
  pts_pkg::tt_wr_t                     tt_wr;
  logic                                rdy_we;
  logic [pts_pkg::RdyAw-1:0]           rdy_waddr, rdy_raddr;
  logic [pts_pkg::TidW-1:0]            rdy_wdata, rdy_rdata;
  logic                                sem_we;
  logic [pts_pkg::SemAw-1:0]           sem_waddr, sem_raddr;
  logic [pts_pkg::TidW-1:0]            sem_wdata, sem_rdata;
  logic                                disp_hit;
  logic [pts_pkg::LvW-1:0]             disp_lv;
  logic [pts_pkg::TidW-1:0]            scan_key;
  logic [pts_pkg::LvW-1:0]             mr_lv;
  logic [pts_pkg::QCntW-1:0]           k_ext;
  logic [pts_pkg::QCntW+pts_pkg::LvW-1:0] rdy_total;

  // storage
  pts_thread_tbl u_tt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (tt_raddr),
    .rd_data_o (tt_rd),
    .wr_i      (tt_wr)
  );

  pts_ram #(
    .Depth (pts_pkg::PrioLevels * pts_pkg::MaxThreads),
    .Width (pts_pkg::TidW)
  ) u_rdy_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rdy_waddr),
    .wdata_i (rdy_wdata),
    .raddr_i (rdy_raddr),
    .rdata_o (rdy_rdata)
  );

  pts_ram #(
    .Depth (pts_pkg::SemSlots * pts_pkg::MaxThreads),
    .Width (pts_pkg::TidW)
  ) u_sem_ram (
    .clk_i   (clk_i),
    .we_i    (sem_we),
    .waddr_i (sem_waddr),
    .wdata_i (sem_wdata),
    .raddr_i (sem_raddr),
    .rdata_o (sem_rdata)
  );

  // first non-empty ready level, level 0 wins
  always_comb begin
    disp_hit = 1'b0;
    disp_lv  = '0;
    for (int l = pts_pkg::PrioLevels - 1; l >= 0; l--) begin
      if (rq_q[l].cnt != '0) begin
        disp_hit = 1'b1;
        disp_lv  = pts_pkg::LvW'(l);
      end
    end
  end

  // occupancy of all ready levels, for checking
  always_comb begin
    rdy_total = '0;
    for (int l = 0; l < pts_pkg::PrioLevels; l++) begin
      rdy_total = rdy_total + (pts_pkg::QCntW + pts_pkg::LvW)'(rq_q[l].cnt);
    end
  end

  assign scan_key = (op_q == pts_pkg::OP_JOIN) ? tid_q : cur_q;
  assign mr_lv    = tt_rd.prio;
  assign k_ext    = {1'b0, k_q};
  assign in_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    prio_d       = prio_q;
    tid_d        = tid_q;
    sid_d        = sid_q;
    initc_d      = initc_q;
    res_d        = res_q;
    newtid_d     = newtid_q;
    run_d        = run_q;
    cur_d        = cur_q;
    next_tid_d   = next_tid_q;
    mr_tid_d     = mr_tid_q;
    disp_after_d = disp_after_q;
    scan_d       = scan_q;
    k_d          = k_q;
    lv_d         = lv_q;
    rq_d         = rq_q;
    sq_d         = sq_q;
    scnt_d       = scnt_q;
    sinit_d      = sinit_q;
    ostat_d      = ostat_q;
    onew_d       = onew_q;
    orun_tid_d   = orun_tid_q;
    orun_v_d     = orun_v_q;
    ov_d         = ov_q && !out_o.ready;

    tt_raddr  = tid_q;
    tt_wr     = '0;
    rdy_we    = 1'b0;
    rdy_waddr = '0;
    rdy_wdata = '0;
    rdy_raddr = '0;
    sem_we    = 1'b0;
    sem_waddr = '0;
    sem_wdata = cur_q;
    sem_raddr = {sid_q, sq_q[sid_q].head};

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d     = pts_pkg::opcode_e'(in_i.opcode);
          prio_d   = in_i.prio;
          tid_d    = in_i.target_tid;
          sid_d    = in_i.sem_id;
          initc_d  = in_i.init_count;
          res_d    = pts_pkg::RES_ERR;
          newtid_d = '0;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_DONE;
        unique case (op_q)
          pts_pkg::OP_CREATE: begin
            if (prio_q < pts_pkg::PrioInW'(pts_pkg::PrioLevels)) begin
              next_tid_d = next_tid_q + 1'b1;
              tid_d      = next_tid_q + 1'b1;
              state_d    = S_CHK;
            end
          end
          pts_pkg::OP_YIELD: begin
            if (run_q) begin
              mr_tid_d     = cur_q;
              disp_after_d = 1'b1;
              state_d      = S_MKRDY;
            end else begin
              state_d = S_DISP;
            end
          end
          pts_pkg::OP_JOIN: begin
            if (run_q) begin
              scan_d  = '0;
              state_d = S_JSCAN;
            end
          end
          pts_pkg::OP_EXIT: begin
            if (run_q) begin
              tt_wr.en          = 1'b1;
              tt_wr.addr        = cur_q;
              tt_wr.prio_we     = 1'b1;
              tt_wr.stat_we     = 1'b1;
              tt_wr.join_we     = 1'b1;
              tt_wr.data.prio   = '0;
              tt_wr.data.stat   = pts_pkg::TS_FREE;
              tt_wr.data.join_v = 1'b0;
              scan_d            = '0;
              state_d           = S_JSCAN;
            end
          end
          pts_pkg::OP_SEM_INIT: begin
            if (!sinit_q[sid_q]) begin
              sinit_d[sid_q] = 1'b1;
              scnt_d[sid_q]  = pts_pkg::SemCntW'(initc_q);
              sq_d[sid_q]    = '0;
              res_d          = pts_pkg::RES_OK;
            end
          end
          pts_pkg::OP_SEM_WAIT: begin
            if (sinit_q[sid_q] && run_q) begin
              if (scnt_q[sid_q] > 0) begin
                scnt_d[sid_q] = scnt_q[sid_q] - pts_pkg::SemCntW'(1);
                res_d         = pts_pkg::RES_OK;
              end else begin
                if (scnt_q[sid_q] != pts_pkg::SemLow) begin
                  scnt_d[sid_q] = scnt_q[sid_q] - pts_pkg::SemCntW'(1);
                end
                tt_wr.en        = 1'b1;
                tt_wr.addr      = cur_q;
                tt_wr.stat_we   = 1'b1;
                tt_wr.data.stat = pts_pkg::TS_BSEM;
                // block the running thread at the semaphore tail
                if (sq_q[sid_q].cnt < pts_pkg::QCntW'(pts_pkg::MaxThreads)) begin
                  sem_we           = 1'b1;
                  sem_waddr        = {sid_q, sq_q[sid_q].tail};
                  sq_d[sid_q].tail = sq_q[sid_q].tail + 1'b1;
                  sq_d[sid_q].cnt  = sq_q[sid_q].cnt + 1'b1;
                end
                state_d = S_DISP;
              end
            end
          end
          pts_pkg::OP_SEM_SIG: begin
            if (sinit_q[sid_q]) begin
              if (scnt_q[sid_q] != pts_pkg::SemHigh) begin
                scnt_d[sid_q] = scnt_q[sid_q] + pts_pkg::SemCntW'(1);
              end
              res_d = pts_pkg::RES_OK;
              // head waiter read issued this cycle
              if (sq_q[sid_q].cnt != '0) begin
                state_d = S_SIGWB;
              end
            end
          end
          pts_pkg::OP_SET_PRIO: begin
            if (prio_q < pts_pkg::PrioInW'(pts_pkg::PrioLevels)) begin
              state_d = S_CHK;
            end
          end
          default: state_d = S_DONE;
        endcase
      end

      // walk the join waits for one naming the key thread
      S_JSCAN: begin
        tt_raddr = scan_q;
        if (tt_rd.join_v && tt_rd.join_tid == scan_key) begin
          if (op_q == pts_pkg::OP_JOIN) begin
            state_d = S_DONE;
          end else begin
            tt_wr.en          = 1'b1;
            tt_wr.addr        = scan_q;
            tt_wr.join_we     = 1'b1;
            tt_wr.data.join_v = 1'b0;
            mr_tid_d          = scan_q;
            disp_after_d      = 1'b1;
            state_d           = S_MKRDY;
          end
        end else if (scan_q == pts_pkg::TidW'(pts_pkg::MaxThreads - 1)) begin
          state_d = (op_q == pts_pkg::OP_JOIN) ? S_CHK : S_DISP;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      // check the addressed thread's entry
      S_CHK: begin
        tt_raddr = tid_q;
        state_d  = S_DONE;
        priority if (op_q == pts_pkg::OP_CREATE) begin
          if (tt_rd.stat == pts_pkg::TS_FREE) begin
            tt_wr.en          = 1'b1;
            tt_wr.addr        = tid_q;
            tt_wr.prio_we     = 1'b1;
            tt_wr.join_we     = 1'b1;
            tt_wr.data.prio   = prio_q[pts_pkg::LvW-1:0];
            tt_wr.data.join_v = 1'b0;
            newtid_d          = tid_q;
            mr_tid_d          = tid_q;
            disp_after_d      = 1'b0;
            state_d           = S_MKRDY;
          end
        end else if (op_q == pts_pkg::OP_JOIN) begin
          if (tt_rd.stat == pts_pkg::TS_READY || tt_rd.stat == pts_pkg::TS_BJOIN ||
              tt_rd.stat == pts_pkg::TS_BSEM) begin
            tt_wr.en            = 1'b1;
            tt_wr.addr          = cur_q;
            tt_wr.stat_we       = 1'b1;
            tt_wr.join_we       = 1'b1;
            tt_wr.data.stat     = pts_pkg::TS_BJOIN;
            tt_wr.data.join_v   = 1'b1;
            tt_wr.data.join_tid = tid_q;
            state_d             = S_DISP;
          end
        end else begin
          if (tt_rd.stat == pts_pkg::TS_READY) begin
            lv_d = tt_rd.prio;
            k_d  = '0;
            state_d = (rq_q[tt_rd.prio].cnt == '0) ? S_SETPFIN : S_RMRD;
          end else if (tt_rd.stat != pts_pkg::TS_FREE) begin
            tt_wr.en        = 1'b1;
            tt_wr.addr      = tid_q;
            tt_wr.prio_we   = 1'b1;
            tt_wr.data.prio = prio_q[pts_pkg::LvW-1:0];
            res_d           = pts_pkg::RES_OK;
          end
        end
      end

      // mark ready and append at the tail of its level
      S_MKRDY: begin
        tt_raddr        = mr_tid_q;
        tt_wr.en        = 1'b1;
        tt_wr.addr      = mr_tid_q;
        tt_wr.stat_we   = 1'b1;
        tt_wr.data.stat = pts_pkg::TS_READY;
        if (rq_q[mr_lv].cnt < pts_pkg::QCntW'(pts_pkg::MaxThreads)) begin
          rdy_we           = 1'b1;
          rdy_waddr        = {mr_lv, rq_q[mr_lv].tail};
          rdy_wdata        = mr_tid_q;
          rq_d[mr_lv].tail = rq_q[mr_lv].tail + 1'b1;
          rq_d[mr_lv].cnt  = rq_q[mr_lv].cnt + 1'b1;
        end
        if (disp_after_q) begin
          state_d = S_DISP;
        end else begin
          res_d   = pts_pkg::RES_OK;
          state_d = S_DONE;
        end
      end

      S_DISP: begin
        rdy_raddr = {disp_lv, rq_q[disp_lv].head};
        lv_d      = disp_lv;
        if (disp_hit) begin
          state_d = S_DISPWB;
        end else begin
          run_d   = 1'b0;
          cur_d   = '0;
          res_d   = pts_pkg::RES_NORUN;
          state_d = S_DONE;
        end
      end

      // popped head becomes the running thread
      S_DISPWB: begin
        rq_d[lv_q].head = rq_q[lv_q].head + 1'b1;
        rq_d[lv_q].cnt  = rq_q[lv_q].cnt - 1'b1;
        tt_wr.en        = 1'b1;
        tt_wr.addr      = rdy_rdata;
        tt_wr.stat_we   = 1'b1;
        tt_wr.data.stat = pts_pkg::TS_RUNNING;
        run_d           = 1'b1;
        cur_d           = rdy_rdata;
        res_d           = pts_pkg::RES_OK;
        state_d         = S_DONE;
      end

      // head waiter of the semaphore goes back to ready
      S_SIGWB: begin
        sq_d[sid_q].head = sq_q[sid_q].head + 1'b1;
        sq_d[sid_q].cnt  = sq_q[sid_q].cnt - 1'b1;
        mr_tid_d         = sem_rdata;
        disp_after_d     = 1'b0;
        state_d          = S_MKRDY;
      end

      // search the old level for the thread
      S_RMRD: begin
        rdy_raddr = {lv_q, rq_q[lv_q].head + k_q};
        state_d   = S_RMCMP;
      end

      S_RMCMP: begin
        if (rdy_rdata == tid_q) begin
          state_d = (k_ext + 1'b1 < rq_q[lv_q].cnt) ? S_SHRD : S_RMEND;
        end else if (k_ext + 1'b1 >= rq_q[lv_q].cnt) begin
          state_d = S_SETPFIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RMRD;
        end
      end

      // close the gap, one entry per read and write pair
      S_SHRD: begin
        rdy_raddr = {lv_q, rq_q[lv_q].head + k_q + 1'b1};
        state_d   = S_SHWR;
      end

      S_SHWR: begin
        rdy_we    = 1'b1;
        rdy_waddr = {lv_q, rq_q[lv_q].head + k_q};
        rdy_wdata = rdy_rdata;
        k_d       = k_q + 1'b1;
        state_d   = (k_ext + 2'd2 < rq_q[lv_q].cnt) ? S_SHRD : S_RMEND;
      end

      S_RMEND: begin
        rq_d[lv_q].tail = rq_q[lv_q].tail - 1'b1;
        rq_d[lv_q].cnt  = rq_q[lv_q].cnt - 1'b1;
        state_d         = S_SETPFIN;
      end

      S_SETPFIN: begin
        tt_wr.en        = 1'b1;
        tt_wr.addr      = tid_q;
        tt_wr.prio_we   = 1'b1;
        tt_wr.data.prio = prio_q[pts_pkg::LvW-1:0];
        mr_tid_d        = tid_q;
        disp_after_d    = 1'b0;
        state_d         = S_MKRDY;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d       = 1'b1;
          ostat_d    = res_q;
          onew_d     = newtid_q;
          orun_tid_d = run_q ? cur_q : '0;
          orun_v_d   = run_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      run_q      <= 1'b1;
      cur_q      <= '0;
      next_tid_q <= '0;
      sinit_q    <= '0;
      ov_q       <= 1'b0;
      for (int l = 0; l < pts_pkg::PrioLevels; l++) begin
        rq_q[l] <= '0;
      end
      for (int s = 0; s < pts_pkg::SemSlots; s++) begin
        sq_q[s]   <= '0;
        scnt_q[s] <= '0;
      end
    end else begin
      state_q    <= state_d;
      run_q      <= run_d;
      cur_q      <= cur_d;
      next_tid_q <= next_tid_d;
      sinit_q    <= sinit_d;
      ov_q       <= ov_d;
      rq_q       <= rq_d;
      sq_q       <= sq_d;
      scnt_q     <= scnt_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    prio_q       <= prio_d;
    tid_q        <= tid_d;
    sid_q        <= sid_d;
    initc_q      <= initc_d;
    res_q        <= res_d;
    newtid_q     <= newtid_d;
    mr_tid_q     <= mr_tid_d;
    disp_after_q <= disp_after_d;
    scan_q       <= scan_d;
    k_q          <= k_d;
    lv_q         <= lv_d;
    ostat_q      <= ostat_d;
    onew_q       <= onew_d;
    orun_tid_q   <= orun_tid_d;
    orun_v_q     <= orun_v_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = ostat_q;
  assign out_o.new_tid       = onew_q;
  assign out_o.running_tid   = orun_tid_q;
  assign out_o.running_valid = orun_v_q;

  // checks
  `PTS_ASSERT(a_norun_idle,
    (out_o.valid && out_o.status == pts_pkg::RES_NORUN) |-> !out_o.running_valid,
    "no-runnable result reports a running thread")
  `PTS_ASSERT(a_newtid_ok,
    (out_o.valid && out_o.new_tid != '0) |-> (out_o.status == pts_pkg::RES_OK),
    "thread id handed out on a failed operation")
  `PTS_ASSERT(a_rdy_bound,
    rdy_total <= (pts_pkg::QCntW + pts_pkg::LvW)'(pts_pkg::MaxThreads),
    "ready queues hold more threads than exist")
  `PTS_ASSERT(a_take_idle,
    (in_i.valid && in_i.ready) |=> (state_q == S_DECODE),
    "accepted item not decoded next cycle")

endmodule
